FILE: sv/rar_pkg.sv
// Package with shared types and constants for the rational arithmetic block.
package rar_pkg;

	localparam logic [2:0] OP_ADD = 3'd0;
	localparam logic [2:0] OP_SUB = 3'd1;
	localparam logic [2:0] OP_MUL = 3'd2;
	localparam logic [2:0] OP_DIV = 3'd3;
	localparam logic [2:0] OP_RCP = 3'd4;

	// Classified operation handed from the front part to the back part.
	typedef struct packed {
		logic [2:0]  op;
		logic        bad;
		logic        an_neg;
		logic [31:0] an_mag;
		logic        ad_neg;
		logic [31:0] ad_mag;
		logic        bn_neg;
		logic [31:0] bn_mag;
		logic        bd_neg;
		logic [31:0] bd_mag;
	} rar_item_t;

endpackage

FILE: sv/rar_divu.sv
// Shared restoring divider, one quotient bit per cycle, with remainder.
module rar_divu (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] dividend,
	input  logic [63:0] divisor,
	output logic        done,
	output logic [63:0] quot,
	output logic [63:0] rem
);

	logic [6:0]  cnt_q;
	logic [63:0] q_q;
	logic [63:0] r_q;
	logic [63:0] d_q;
	logic [64:0] trial;

	assign trial = {r_q, q_q[63]} - {1'b0, d_q};
	assign quot = q_q;
	assign rem = r_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 7'd0;
			done <= 1'b0;
		end else begin
			done <= (cnt_q == 7'd1);
			if (start) begin
				cnt_q <= 7'd64;
			end else if (cnt_q != 7'd0) begin
				cnt_q <= cnt_q - 7'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			q_q <= dividend;
			r_q <= 64'd0;
			d_q <= divisor;
		end else if (cnt_q != 7'd0) begin
			if (!trial[64]) begin
				r_q <= trial[63:0];
				q_q <= {q_q[62:0], 1'b1};
			end else begin
				r_q <= {r_q[62:0], q_q[63]};
				q_q <= {q_q[62:0], 1'b0};
			end
		end
	end

endmodule

FILE: sv/rar_front.sv
// Front part: takes operands, splits sign and magnitude, flags bad ops and queues them.
module rar_front #(
	parameter int OPERAND_WIDTH = 32
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    valid,
	output logic                    stall,
	input  logic [2:0]              op,
	input  logic signed [31:0]      a_num,
	input  logic signed [31:0]      a_den,
	input  logic signed [31:0]      b_num,
	input  logic signed [31:0]      b_den,
	output logic                    q_valid,
	input  logic                    q_stall,
	output rar_pkg::rar_item_t      q_item
);

	localparam int QD = 2;

	rar_pkg::rar_item_t fifo_q [QD];
	logic        wp_q;
	logic        rp_q;
	logic [1:0]  cnt_q;
	rar_pkg::rar_item_t item;
	logic push;
	logic pop;

	function automatic logic [32:0] take(input logic [31:0] raw);
		logic [OPERAND_WIDTH-1:0] x;
		logic [OPERAND_WIDTH-1:0] m;
		begin
			x = raw[OPERAND_WIDTH-1:0];
			m = x[OPERAND_WIDTH-1] ? (~x + 1'b1) : x;
			take = {x[OPERAND_WIDTH-1], 32'(m)};
		end
	endfunction

	always_comb begin
		item.op = op;
		item.bad = !(op == rar_pkg::OP_ADD || op == rar_pkg::OP_SUB
			|| op == rar_pkg::OP_MUL || op == rar_pkg::OP_DIV
			|| op == rar_pkg::OP_RCP);
		{item.an_neg, item.an_mag} = take(a_num);
		{item.ad_neg, item.ad_mag} = take(a_den);
		{item.bn_neg, item.bn_mag} = take(b_num);
		{item.bd_neg, item.bd_mag} = take(b_den);
	end

	assign stall = (cnt_q == 2'(QD));
	assign push = valid && !stall;
	assign q_valid = (cnt_q != 2'd0);
	assign pop = q_valid && !q_stall;
	assign q_item = fifo_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (pop) rp_q <= ~rp_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (push) fifo_q[wp_q] <= item;
	end

endmodule

FILE: sv/rar_back.sv
// Back part: normalizes operands, cross-multiplies and reduces by the GCD.
module rar_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               q_valid,
	output logic               q_stall,
	input  rar_pkg::rar_item_t q_item,
	output logic               valid,
	input  logic               stall,
	output logic signed [63:0] res_num,
	output logic [62:0]        res_den,
	output logic               status
);

	localparam logic [3:0] ST_IDLE  = 4'd0;
	localparam logic [3:0] ST_GCD   = 4'd1;
	localparam logic [3:0] ST_GWAIT = 4'd2;
	localparam logic [3:0] ST_DIVN  = 4'd3;
	localparam logic [3:0] ST_NWAIT = 4'd4;
	localparam logic [3:0] ST_DIVD  = 4'd5;
	localparam logic [3:0] ST_DWAIT = 4'd6;
	localparam logic [3:0] ST_NEXT  = 4'd7;
	localparam logic [3:0] ST_MUL1  = 4'd8;
	localparam logic [3:0] ST_MUL2  = 4'd9;
	localparam logic [3:0] ST_OUT   = 4'd10;

	// Phase 0 and 1 reduce operand a and b; phase 2 reduces the result.
	logic [3:0]  state_q;
	logic [1:0]  phase_q;
	rar_pkg::rar_item_t it_q;
	logic [63:0] x_q;
	logic [63:0] y_q;
	logic [63:0] n_q;
	logic [63:0] d_q;
	logic        nneg_q;
	logic [63:0] p1_q;
	logic [63:0] p2_q;
	logic [63:0] p3_q;
	logic        full_q;

	logic        dv_start;
	logic [63:0] dv_a;
	logic [63:0] dv_b;
	logic        dv_done;
	logic [63:0] dv_q;
	logic [63:0] dv_r;

	rar_divu u_div (
		.clk(clk), .arst_n(arst_n), .start(dv_start), .dividend(dv_a),
		.divisor(dv_b), .done(dv_done), .quot(dv_q), .rem(dv_r)
	);

	assign dv_start = (state_q == ST_GCD && x_q != 64'd0)
		|| state_q == ST_DIVN || state_q == ST_DIVD;
	always_comb begin
		case (state_q)
			ST_GCD: begin
				dv_a = y_q;
				dv_b = x_q;
			end
			ST_DIVN: begin
				dv_a = n_q;
				dv_b = y_q;
			end
			default: begin
				dv_a = d_q;
				dv_b = y_q;
			end
		endcase
	end

	assign q_stall = (state_q != ST_IDLE);
	assign valid = full_q;

	logic [63:0] num_sum;
	logic        num_sneg;
	logic        t2neg;
	always_comb begin
		t2neg = it_q.bn_neg ^ (it_q.op == rar_pkg::OP_SUB);
		if (it_q.an_neg == t2neg) begin
			num_sneg = it_q.an_neg;
			num_sum = p1_q + p2_q;
		end else if (p1_q >= p2_q) begin
			num_sneg = it_q.an_neg;
			num_sum = p1_q - p2_q;
		end else begin
			num_sneg = t2neg;
			num_sum = p2_q - p1_q;
		end
	end

	// Raw numerator and denominator of the result before reduction.
	logic [63:0] raw_num;
	logic        raw_neg;
	logic [63:0] raw_den;
	always_comb begin
		case (it_q.op)
			rar_pkg::OP_ADD, rar_pkg::OP_SUB: begin
				raw_num = num_sum;
				raw_neg = num_sneg;
				raw_den = p3_q;
			end
			rar_pkg::OP_MUL: begin
				raw_num = 64'(it_q.an_mag) * 64'(it_q.bn_mag);
				raw_neg = it_q.an_neg ^ it_q.bn_neg;
				raw_den = p3_q;
			end
			rar_pkg::OP_DIV: begin
				raw_num = p1_q;
				raw_neg = it_q.an_neg ^ it_q.bn_neg;
				raw_den = 64'(it_q.ad_mag) * 64'(it_q.bn_mag);
			end
			rar_pkg::OP_RCP: begin
				raw_num = {32'd0, it_q.ad_mag};
				raw_neg = it_q.an_neg;
				raw_den = {32'd0, it_q.an_mag};
			end
			default: begin
				raw_num = 64'd0;
				raw_neg = 1'b0;
				raw_den = 64'd0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			phase_q <= 2'd0;
			full_q <= 1'b0;
		end else begin
			if (state_q == ST_OUT && (!full_q || !stall)) full_q <= 1'b1;
			else if (full_q && !stall) full_q <= 1'b0;
			case (state_q)
				ST_IDLE: if (q_valid) begin
					state_q <= ST_GCD;
					phase_q <= 2'd0;
				end
				ST_GCD: state_q <= (x_q == 64'd0) ? ST_DIVN : ST_GWAIT;
				ST_GWAIT: if (dv_done) state_q <= ST_GCD;
				ST_DIVN: state_q <= ST_NWAIT;
				ST_NWAIT: if (dv_done) state_q <= ST_DIVD;
				ST_DIVD: state_q <= ST_DWAIT;
				ST_DWAIT: if (dv_done) state_q <= ST_NEXT;
				ST_NEXT: begin
					if (phase_q == 2'd0) begin
						phase_q <= 2'd1;
						state_q <= ST_GCD;
					end else if (phase_q == 2'd1) begin
						state_q <= ST_MUL1;
					end else begin
						state_q <= ST_OUT;
					end
				end
				ST_MUL1: state_q <= ST_MUL2;
				ST_MUL2: begin
					if (it_q.bad || raw_den == 64'd0) begin
						state_q <= ST_OUT;
					end else begin
						phase_q <= 2'd2;
						state_q <= ST_GCD;
					end
				end
				ST_OUT: if (!full_q || !stall) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				it_q <= q_item;
				n_q <= {32'd0, q_item.an_mag};
				d_q <= (q_item.ad_mag == 32'd0) ? 64'd1 : {32'd0, q_item.ad_mag};
				x_q <= {32'd0, q_item.an_mag};
				y_q <= (q_item.ad_mag == 32'd0) ? 64'd1 : {32'd0, q_item.ad_mag};
			end
			ST_GWAIT: if (dv_done) begin
				y_q <= x_q;
				x_q <= dv_r;
			end
			ST_NWAIT: if (dv_done) n_q <= dv_q;
			ST_DWAIT: if (dv_done) d_q <= dv_q;
			ST_NEXT: begin
				if (phase_q == 2'd0) begin
					it_q.an_mag <= n_q[31:0];
					it_q.an_neg <= (n_q != 64'd0) && (it_q.an_neg != it_q.ad_neg);
					it_q.ad_mag <= d_q[31:0];
					n_q <= {32'd0, it_q.bn_mag};
					d_q <= (it_q.bd_mag == 32'd0) ? 64'd1 : {32'd0, it_q.bd_mag};
					x_q <= {32'd0, it_q.bn_mag};
					y_q <= (it_q.bd_mag == 32'd0) ? 64'd1 : {32'd0, it_q.bd_mag};
				end else if (phase_q == 2'd1) begin
					it_q.bn_mag <= n_q[31:0];
					it_q.bn_neg <= (n_q != 64'd0) && (it_q.bn_neg != it_q.bd_neg);
					it_q.bd_mag <= d_q[31:0];
				end
			end
			ST_MUL1: begin
				p1_q <= 64'(it_q.an_mag) * 64'(it_q.bd_mag);
				p2_q <= 64'(it_q.bn_mag) * 64'(it_q.ad_mag);
				p3_q <= 64'(it_q.ad_mag) * 64'(it_q.bd_mag);
			end
			ST_MUL2: begin
				// The result GCD starts from the raw numerator and denominator.
				n_q <= raw_num;
				nneg_q <= raw_neg;
				d_q <= raw_den;
				x_q <= raw_num;
				y_q <= raw_den;
			end
			ST_OUT: if (!full_q || !stall) begin
				if (phase_q != 2'd2) begin
					res_num <= 64'd0;
					res_den <= 63'd1;
					status <= 1'b1;
				end else if (n_q == 64'd0) begin
					res_num <= 64'd0;
					res_den <= 63'd1;
					status <= 1'b0;
				end else begin
					if (n_q[63]) begin
						res_num <= nneg_q ? 64'h8000_0000_0000_0001
							: 64'h7FFF_FFFF_FFFF_FFFF;
					end else begin
						res_num <= nneg_q ? (~{1'b0, n_q[62:0]} + 64'd1)
							: {1'b0, n_q[62:0]};
					end
					res_den <= d_q[62:0];
					status <= 1'b0;
				end
			end
			default: ;
		endcase
	end

endmodule

FILE: sv/rational_arith_reduce.sv
// Top level of the rational arithmetic block with GCD reduction.
// One transaction runs up to three Euclid GCDs and up to six quotients on a
// shared 64-bit divider that produces one quotient bit per cycle, each GCD
// step being one division. The count of Euclid steps sets the time: up to
// about 45 steps for each reduced operand and about 91 for the result.
// A two-entry queue lets the next transaction be taken while one is worked,
// and the result register holds a finished result while the next is worked.
module rational_arith_reduce #(
	parameter int OPERAND_WIDTH = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [2:0]         op,
	input  logic signed [31:0] a_num,
	input  logic signed [31:0] a_den,
	input  logic signed [31:0] b_num,
	input  logic signed [31:0] b_den,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [63:0] res_num,
	output logic [62:0]        res_den,
	output logic               status
);

	logic               q_valid;
	logic               q_stall;
	rar_pkg::rar_item_t q_item;

	rar_front #(.OPERAND_WIDTH(OPERAND_WIDTH)) u_front (
		.clk(clk), .arst_n(arst_n), .valid(in_valid), .stall(in_stall), .op(op),
		.a_num(a_num), .a_den(a_den), .b_num(b_num), .b_den(b_den),
		.q_valid(q_valid), .q_stall(q_stall), .q_item(q_item)
	);

	rar_back u_back (
		.clk(clk), .arst_n(arst_n), .q_valid(q_valid), .q_stall(q_stall),
		.q_item(q_item), .valid(out_valid), .stall(out_stall),
		.res_num(res_num), .res_den(res_den), .status(status)
	);

endmodule

FILE: dv/tb_rational_arith_reduce.sv
// Self-checking testbench for the rational arithmetic block with GCD reduction.
`timescale 1ns / 1ps

module tb_rational_arith_reduce;

	typedef struct {
		logic [2:0]         op;
		logic signed [31:0] a_num;
		logic signed [31:0] a_den;
		logic signed [31:0] b_num;
		logic signed [31:0] b_den;
		bit                 drain_first;
	} frac_req_t;

	typedef struct {
		logic signed [63:0] res_num;
		logic [62:0]        res_den;
		logic               status;
	} frac_res_t;

	logic               clk;
	logic               arst_n;
	logic               in_valid = 1'b0;
	logic               in_stall;
	logic [2:0]         op = '0;
	logic signed [31:0] a_num = '0;
	logic signed [31:0] a_den = '0;
	logic signed [31:0] b_num = '0;
	logic signed [31:0] b_den = '0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic signed [63:0] res_num;
	logic [62:0]        res_den;
	logic               status;

	frac_req_t pending_reqs[$];
	frac_res_t expected_results[$];
	int        send_idle_pct;
	int        recv_idle_pct;
	int        mismatches = 0;
	int        accepted_reqs = 0;
	bit        req_taken = 1'b0;

	rational_arith_reduce dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.op        (op),
		.a_num     (a_num),
		.a_den     (a_den),
		.b_num     (b_num),
		.b_den     (b_den),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.res_num   (res_num),
		.res_den   (res_den),
		.status    (status)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	function automatic longint unsigned euclid_gcd(longint unsigned x, longint unsigned y);
		longint unsigned t;
		while (x != 0) begin
			t = y % x;
			y = x;
			x = t;
		end
		return y;
	endfunction

	function automatic void split_sign(input logic [31:0] v, output bit neg,
			output longint unsigned mag);
		logic [31:0] negated;
		negated = -v;
		neg = v[31];
		mag = neg ? 64'(negated) : 64'(v);
	endfunction

	// Zero denominator counts as one; the sign ends up on the numerator.
	function automatic void reduce_operand(inout bit nneg, inout longint unsigned nmag,
			inout bit dneg, inout longint unsigned dmag);
		longint unsigned g;
		if (dmag == 0) begin
			dmag = 1;
			dneg = 1'b0;
		end
		g = euclid_gcd(nmag, dmag);
		nmag = nmag / g;
		dmag = dmag / g;
		nneg = (nmag != 0) && (nneg != dneg);
		dneg = 1'b0;
	endfunction

	function automatic frac_res_t fraction_result(frac_req_t r);
		frac_res_t res;
		bit an_n, ad_n, bn_n, bd_n, num_n, t_n, bad;
		longint unsigned an_m, ad_m, bn_m, bd_m, num_m, t_m, den, g;
		split_sign(r.a_num, an_n, an_m);
		split_sign(r.a_den, ad_n, ad_m);
		split_sign(r.b_num, bn_n, bn_m);
		split_sign(r.b_den, bd_n, bd_m);
		reduce_operand(an_n, an_m, ad_n, ad_m);
		reduce_operand(bn_n, bn_m, bd_n, bd_m);
		num_n = 1'b0;
		num_m = 0;
		den = 0;
		bad = 1'b0;
		case (r.op)
			rar_pkg::OP_ADD, rar_pkg::OP_SUB: begin
				num_n = an_n;
				num_m = an_m * bd_m;
				t_n = (r.op == rar_pkg::OP_SUB) ? !bn_n : bn_n;
				t_m = bn_m * ad_m;
				if (num_n == t_n) begin
					num_m = num_m + t_m;
				end else if (num_m >= t_m) begin
					num_m = num_m - t_m;
				end else begin
					num_n = t_n;
					num_m = t_m - num_m;
				end
				den = ad_m * bd_m;
			end
			rar_pkg::OP_MUL: begin
				num_n = an_n != bn_n;
				num_m = an_m * bn_m;
				den = ad_m * bd_m;
			end
			rar_pkg::OP_DIV: begin
				num_n = an_n != bn_n;
				num_m = an_m * bd_m;
				den = ad_m * bn_m;
			end
			rar_pkg::OP_RCP: begin
				num_n = an_n;
				num_m = ad_m;
				den = an_m;
			end
			default: bad = 1'b1;
		endcase
		if (bad || den == 0) begin
			res.res_num = '0;
			res.res_den = 63'd1;
			res.status = 1'b1;
			return res;
		end
		g = euclid_gcd(num_m, den);
		num_m = num_m / g;
		den = den / g;
		if (num_m == 0) begin
			num_n = 1'b0;
			den = 1;
		end
		if (num_m > 64'h7fff_ffff_ffff_ffff)
			num_m = 64'h7fff_ffff_ffff_ffff;
		res.res_num = num_n ? -num_m : num_m;
		res.res_den = den[62:0];
		res.status = 1'b0;
		return res;
	endfunction

	function automatic logic [31:0] rand_operand();
		logic [31:0] v;
		case ($urandom_range(3))
			0: v = $urandom_range(40) - 20;
			1: v = $urandom_range(2000) - 1000;
			2: v = {{16{1'b0}}, 16'($urandom)} * (($urandom_range(1)) ? 1 : -1);
			default: v = $urandom;
		endcase
		if (v == 32'h8000_0000)
			v = 32'h8000_0001;
		return v;
	endfunction

	task automatic queue_req(logic [2:0] o, logic [31:0] an, logic [31:0] ad,
			logic [31:0] bn, logic [31:0] bd, bit drain);
		frac_req_t r;
		r.op = o;
		r.a_num = an;
		r.a_den = ad;
		r.b_num = bn;
		r.b_den = bd;
		r.drain_first = drain;
		pending_reqs.push_back(r);
	endtask

	// Stimulus: directed corner cases followed by random fractions.
	initial begin
		logic [2:0] o;
		queue_req(rar_pkg::OP_ADD, 32'sd1, 32'sd2, 32'sd1, 32'sd3, 1'b0);
		queue_req(rar_pkg::OP_SUB, 32'sd1, 32'sd2, 32'sd1, 32'sd2, 1'b0);
		queue_req(rar_pkg::OP_MUL, -32'sd4, 32'sd6, 32'sd3, -32'sd8, 1'b0);
		queue_req(rar_pkg::OP_DIV, 32'sd3, 32'sd7, -32'sd9, 32'sd14, 1'b0);
		queue_req(rar_pkg::OP_RCP, -32'sd5, 32'sd10, 32'sd77, 32'sd0, 1'b0);
		queue_req(rar_pkg::OP_ADD, 32'sd5, 32'sd0, 32'sd7, 32'sd0, 1'b0);
		queue_req(rar_pkg::OP_DIV, 32'sd5, 32'sd3, 32'sd0, 32'sd9, 1'b0);
		queue_req(rar_pkg::OP_RCP, 32'sd0, 32'sd3, 32'sd1, 32'sd1, 1'b0);
		queue_req(3'd5, 32'sd1, 32'sd1, 32'sd1, 32'sd1, 1'b0);
		queue_req(3'd6, 32'sd1, 32'sd1, 32'sd1, 32'sd1, 1'b0);
		queue_req(3'd7, -32'sd1, -32'sd1, -32'sd1, -32'sd1, 1'b0);
		queue_req(rar_pkg::OP_MUL, 32'sd0, -32'sd5, 32'sd9, 32'sd4, 1'b0);
		queue_req(rar_pkg::OP_ADD, 32'h7fff_ffff, 32'sd1, 32'h7fff_ffff, 32'sd1, 1'b0);
		queue_req(rar_pkg::OP_SUB, 32'h8000_0001, 32'sd1, 32'h7fff_ffff, 32'sd1, 1'b0);
		queue_req(rar_pkg::OP_MUL, 32'h7fff_ffff, 32'h7fff_fffe, 32'h8000_0001,
			32'h7fff_fffd, 1'b0);
		queue_req(rar_pkg::OP_DIV, 32'h7fff_ffff, 32'h8000_0001, 32'h7fff_fffe,
			32'h7fff_ffff, 1'b0);
		queue_req(rar_pkg::OP_ADD, 32'sd1, 32'h7fff_ffff, 32'sd1, 32'h7fff_fffe, 1'b0);
		queue_req(rar_pkg::OP_RCP, 32'h8000_0001, -32'sd1, 32'sd0, 32'sd0, 1'b0);
		queue_req(rar_pkg::OP_SUB, -32'sd6, -32'sd4, -32'sd6, -32'sd4, 1'b0);
		queue_req(rar_pkg::OP_DIV, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 1'b0);
		for (int i = 0; i < 1530; i++) begin
			o = ($urandom_range(99) < 3) ? 3'($urandom_range(7, 5)) : 3'($urandom_range(4));
			queue_req(o, rand_operand(), rand_operand(), rand_operand(), rand_operand(),
				(i == 300) || (i == 1100));
		end
	end

	initial begin
		send_idle_pct = 11;
		recv_idle_pct = 59;
		arst_n = 1'b0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		wait (accepted_reqs >= 520);
		send_idle_pct = 59;
		recv_idle_pct = 11;
		wait (accepted_reqs >= 1040);
		send_idle_pct = 0;
		recv_idle_pct = 0;
	end

	// Driver: presents the next transaction once the previous one is taken.
	always @(negedge clk) begin
		if (arst_n) begin
			out_stall <= ($urandom_range(99) < recv_idle_pct);
			if (!in_valid || req_taken) begin
				if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct &&
						!(pending_reqs[0].drain_first && expected_results.size() != 0)) begin
					frac_req_t r;
					r = pending_reqs.pop_front();
					in_valid <= 1'b1;
					op <= r.op;
					a_num <= r.a_num;
					a_den <= r.a_den;
					b_num <= r.b_num;
					b_den <= r.b_den;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Monitor: predicts on input transactions, checks output transactions.
	always @(posedge clk) begin
		frac_req_t r;
		frac_res_t want;
		req_taken <= arst_n && in_valid && !in_stall;
		if (arst_n && in_valid && !in_stall) begin
			r.op = op;
			r.a_num = a_num;
			r.a_den = a_den;
			r.b_num = b_num;
			r.b_den = b_den;
			r.drain_first = 1'b0;
			expected_results.push_back(fraction_result(r));
			accepted_reqs <= accepted_reqs + 1;
		end
		if (arst_n && out_valid && !out_stall) begin
			if (expected_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("ERROR: unexpected result %0d/%0d status %0d",
						res_num, res_den, status);
			end else begin
				want = expected_results.pop_front();
				if (res_num !== want.res_num || res_den !== want.res_den ||
						status !== want.status) begin
					mismatches++;
					if (mismatches <= 10)
						$display("ERROR: expected %0d/%0d status %0d, got %0d/%0d status %0d",
							want.res_num, want.res_den, want.status,
							res_num, res_den, status);
				end
			end
		end
	end

	initial begin
		#1;
		wait (pending_reqs.size() == 0 && !in_valid && arst_n);
		wait (expected_results.size() == 0);
		repeat (20000) @(posedge clk);
		if (mismatches == 0 && expected_results.size() == 0)
			$display("PASS rational_arith_reduce");
		else
			$display("FAIL rational_arith_reduce");
		$finish;
	end

	initial begin
		#400ms;
		$display("FAIL rational_arith_reduce");
		$finish;
	end

endmodule
